@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/msniff_pkg.sv @@
// types and constants of the modbus read-response sniffer
// no dependencies
package msniff_pkg;

    localparam int WIDX_W = 5;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] BYTES_BANK0 = 8'h0C;
    localparam logic [7:0] BYTES_BANK1 = 8'h20;
    localparam logic [7:0] BYTES_BANK2 = 8'h02;
    localparam logic [7:0] BYTES_BANK3 = 8'h2C;

    localparam logic [WIDX_W-1:0] LAST_IDX_BANK0 = 5'd5;
    localparam logic [WIDX_W-1:0] LAST_IDX_BANK1 = 5'd15;
    localparam logic [WIDX_W-1:0] LAST_IDX_BANK2 = 5'd0;
    localparam logic [WIDX_W-1:0] LAST_IDX_BANK3 = 5'd21;

    localparam logic [7:0] RESET_SLAVE_ADDRESS = 8'd1;
    localparam logic [15:0] RESET_HEADER_LIMIT = 16'd50;
    localparam logic [15:0] RESET_PAYLOAD_LIMIT = 16'd100;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        REG_SLAVE_ADDRESS = 2'd0,
        REG_HEADER_LIMIT  = 2'd1,
        REG_PAYLOAD_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        BANK_SIX    = 2'd0,
        BANK_SIXTEEN = 2'd1,
        BANK_ONE    = 2'd2,
        BANK_WIDE   = 2'd3
    } bank_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_SHOW = 2'd2
    } em_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       write_pending;
    } in_beat_t;

    typedef struct packed {
        bank_t             bank;
        logic [WIDX_W-1:0] word_index;
        logic [15:0]       word_value;
        logic              last;
        logic              write_grant;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] header_limit;
        logic [15:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        bank_t             bank;
        logic [WIDX_W-1:0] last_index;
        logic              grant;
    } emit_req_t;

endpackage

@@ rtl/msniff_store.sv @@
// payload byte store: even and odd byte memories, one registered word read
// depends on msniff_pkg
module msniff_store
    import msniff_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(BUFFER_BYTES)-2:0] rd_addr,
    output logic [15:0]                     rd_data
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int WORDS = (BUFFER_BYTES + 1) / 2;

    logic [7:0] even_mem [WORDS];
    logic [7:0] odd_mem [WORDS];
    logic [7:0] hi_reg;
    logic [7:0] lo_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_addr[0]) begin
            even_mem[wr_addr[ADDR_W-1:1]] <= wr_data;
        end
        if (wr_en && wr_addr[0]) begin
            odd_mem[wr_addr[ADDR_W-1:1]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hi_reg <= even_mem[rd_addr];
            lo_reg <= odd_mem[rd_addr];
        end
    end

    assign rd_data = {hi_reg, lo_reg};

endmodule

@@ rtl/msniff_frame.sv @@
// frame tracker: address hunt, header, payload, tick timeouts, store writes
// depends on msniff_pkg
module msniff_frame
    import msniff_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            beat_ok,
    input  in_beat_t                        in_data,
    input  cfg_t                            cfg,
    output logic                            wr_en,
    output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    output logic [7:0]                      wr_data,
    output emit_req_t                       emit_req
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    phase_t           phase_reg, phase_next;
    logic [7:0]       code_reg, code_next;
    logic [CNT_W-1:0] expected_reg, expected_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      ticks_reg, ticks_next;

    logic [15:0]      ticks_inc;
    logic [CNT_W-1:0] count_inc;
    logic             too_big;

    assign ticks_inc = (ticks_reg == TICKS_MAX) ? ticks_reg : ticks_reg + 16'd1;
    assign count_inc = count_reg + CNT_W'(1);
    assign too_big = {1'b0, in_data.rx_byte} > 9'(BUFFER_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            code_reg <= '0;
            expected_reg <= '0;
            count_reg <= '0;
            ticks_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            code_reg <= code_next;
            expected_reg <= expected_next;
            count_reg <= count_next;
            ticks_reg <= ticks_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        code_next = code_reg;
        expected_next = expected_reg;
        count_next = count_reg;
        ticks_next = ticks_reg;
        wr_en = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = in_data.rx_byte;
        emit_req = '0;

        if (beat_ok && in_data.mode == MODE_TICK) begin
            unique case (phase_reg)
                PH_HEADER, PH_PAYLOAD: begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > ((phase_reg == PH_HEADER) ? cfg.header_limit
                                                              : cfg.payload_limit)) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        ticks_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (beat_ok && in_data.mode == MODE_BYTE) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (count_reg == '0) begin
                        code_next = in_data.rx_byte;
                        count_next = CNT_W'(1);
                    end else if (code_reg != FUNC_READ_HOLDING || too_big) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        ticks_next = '0;
                    end else begin
                        expected_next = CNT_W'(in_data.rx_byte);
                        count_next = '0;
                        ticks_next = '0;
                        phase_next = (in_data.rx_byte == 8'd0) ? PH_HUNT : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    wr_en = 1'b1;
                    if (count_inc < expected_reg) begin
                        count_next = count_inc;
                    end else begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        ticks_next = '0;
                        if (expected_reg == CNT_W'(BYTES_BANK0)) begin
                            emit_req = '{valid: 1'b1, bank: BANK_SIX,
                                         last_index: LAST_IDX_BANK0, grant: 1'b0};
                        end else if (expected_reg == CNT_W'(BYTES_BANK1)) begin
                            emit_req = '{valid: 1'b1, bank: BANK_SIXTEEN,
                                         last_index: LAST_IDX_BANK1, grant: 1'b0};
                        end else if (expected_reg == CNT_W'(BYTES_BANK2)) begin
                            emit_req = '{valid: 1'b1, bank: BANK_ONE,
                                         last_index: LAST_IDX_BANK2, grant: 1'b0};
                        end else if (expected_reg == CNT_W'(BYTES_BANK3)) begin
                            emit_req = '{valid: 1'b1, bank: BANK_WIDE,
                                         last_index: LAST_IDX_BANK3,
                                         grant: in_data.write_pending};
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (in_data.rx_byte == cfg.slave_address) begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        ticks_next = '0;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/msniff_emit.sv @@
// word sequencer: reads the store one word at a time and presents result beats
// depends on msniff_pkg
module msniff_emit
    import msniff_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  emit_req_t                       req,
    output logic                            rd_en,
    output logic [$clog2(BUFFER_BYTES)-2:0] rd_addr,
    input  logic [15:0]                     rd_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output out_beat_t                       m_data,
    output logic                            busy
);

    localparam int WADDR_W = $clog2(BUFFER_BYTES) - 1;

    em_state_t         state_reg, state_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic [WIDX_W-1:0] last_idx_reg, last_idx_next;
    bank_t             bank_reg, bank_next;
    logic              grant_reg, grant_next;
    logic              is_last;

    assign is_last = idx_reg == last_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        last_idx_reg <= last_idx_next;
        bank_reg <= bank_next;
        grant_reg <= grant_next;
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        last_idx_next = last_idx_reg;
        bank_next = bank_reg;
        grant_next = grant_reg;
        rd_en = 1'b0;
        rd_addr = WADDR_W'(idx_reg);
        m_valid = 1'b0;
        unique case (state_reg)
            EM_IDLE: begin
                if (req.valid) begin
                    state_next = EM_READ;
                    idx_next = '0;
                    last_idx_next = req.last_index;
                    bank_next = req.bank;
                    grant_next = req.grant;
                end
            end
            EM_READ: begin
                rd_en = 1'b1;
                state_next = EM_SHOW;
            end
            EM_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (is_last) begin
                        state_next = EM_IDLE;
                    end else begin
                        idx_next = idx_reg + WIDX_W'(1);
                        state_next = EM_READ;
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign busy = state_reg != EM_IDLE;

    assign m_data = '{bank: bank_reg, word_index: idx_reg, word_value: rd_data,
                      last: is_last, write_grant: is_last && grant_reg};

endmodule

@@ rtl/modbus_response_sniffer.sv @@
// Modbus RTU read-response sniffer. Each input beat (a received byte or a
// millisecond tick) is accepted while no word run is in progress.
// A completed 12, 32, 2 or 44 byte payload releases 6, 16, 1 or 22 result
// beats; each word is one read of the payload memory and then a wait in
// the output register until it is taken, and s_ready stays low until the
// last word of the run is taken. The payload memory needs no clearing
// pass. Configuration writes are taken in any cycle. Depends on msniff_pkg
// and the msniff_* submodules.
module modbus_response_sniffer
    import msniff_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    cfg_t              cfg_reg;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-2:0] rd_addr;
    logic [15:0]       rd_data;
    emit_req_t         emit_req;

    assign cfg_ready = 1'b1;
    assign s_ready = !busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{slave_address: RESET_SLAVE_ADDRESS,
                         header_limit: RESET_HEADER_LIMIT,
                         payload_limit: RESET_PAYLOAD_LIMIT};
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_data[7:0];
                REG_HEADER_LIMIT:  cfg_reg.header_limit <= cfg_data;
                REG_PAYLOAD_LIMIT: cfg_reg.payload_limit <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    msniff_frame #(.BUFFER_BYTES(BUFFER_BYTES)) u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_ok  (s_valid && s_ready),
        .in_data  (s_data),
        .cfg      (cfg_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .emit_req (emit_req)
    );

    msniff_store #(.BUFFER_BYTES(BUFFER_BYTES)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    msniff_emit #(.BUFFER_BYTES(BUFFER_BYTES)) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (emit_req),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .busy    (busy)
    );

endmodule

@@ rtl/msniff_checker.sv @@
// port-level checks for the read-response sniffer, bound to the top level
// depends on msniff_pkg and assert_macros.svh
`include "assert_macros.svh"

module msniff_checker
    import msniff_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // no input beat taken while a word is on offer
    `ASSERT_IMPLIES(a_no_in_during_out, aclk, aresetn, m_valid, !s_ready)
    // grant only on the last word of a wide bank
    `ASSERT_IMPLIES(a_grant_last, aclk, aresetn, m_valid && m_data.write_grant, m_data.last && m_data.bank == BANK_WIDE)
    // the run continues after a word that is not last
    `ASSERT_NEXT(a_run_continues, aclk, aresetn, m_valid && m_ready && !m_data.last, !s_ready)

endmodule

bind modbus_response_sniffer msniff_checker u_msniff_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/msniff_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard for the modbus read-response sniffer: predicts the word beats
// that each accepted input beat releases and checks the output against them
// depends on msniff_pkg
package msniff_scoreboard_pkg;
    import msniff_pkg::*;

    class register_word_tracker;
        localparam int BUF_BYTES = 64;

        logic [7:0]  slave_address;
        logic [15:0] header_limit;
        logic [15:0] payload_limit;

        phase_t      phase;
        logic [7:0]  header_code;
        logic [6:0]  expected_bytes;
        logic [6:0]  received_count;
        logic [15:0] elapsed;
        logic [7:0]  payload [BUF_BYTES];

        out_beat_t   awaited_words [$];
        int          errors;

        function new();
            slave_address = RESET_SLAVE_ADDRESS;
            header_limit = RESET_HEADER_LIMIT;
            payload_limit = RESET_PAYLOAD_LIMIT;
            phase = PH_HUNT;
            header_code = '0;
            expected_bytes = '0;
            received_count = '0;
            elapsed = '0;
            foreach (payload[i]) payload[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [15:0] value);
            case (idx)
                REG_SLAVE_ADDRESS: slave_address = value[7:0];
                REG_HEADER_LIMIT:  header_limit = value;
                REG_PAYLOAD_LIMIT: payload_limit = value;
                default: ;
            endcase
        endfunction

        function int waiting();
            return awaited_words.size();
        endfunction

        function void drop_frame();
            phase = PH_HUNT;
            received_count = '0;
            elapsed = '0;
        endfunction

        function void queue_run(bank_t bank, int nwords, logic grant);
            out_beat_t w;
            for (int i = 0; i < nwords; i++) begin
                w.bank = bank;
                w.word_index = 5'(i);
                w.word_value = {payload[2 * i], payload[2 * i + 1]};
                w.last = (i == nwords - 1);
                w.write_grant = (i == nwords - 1) && grant;
                awaited_words.push_back(w);
            end
        endfunction

        function void take_beat(in_beat_t beat);
            logic [15:0] limit;
            if (beat.mode == MODE_TICK) begin
                if (phase == PH_HEADER || phase == PH_PAYLOAD) begin
                    limit = (phase == PH_HEADER) ? header_limit : payload_limit;
                    if (elapsed != TICKS_MAX) elapsed++;
                    if (elapsed > limit) drop_frame();
                end
                return;
            end
            case (phase)
                PH_HEADER: begin
                    if (received_count == 0) begin
                        header_code = beat.rx_byte;
                        received_count = 1;
                    end else if (header_code != FUNC_READ_HOLDING || beat.rx_byte > BUF_BYTES) begin
                        drop_frame();
                    end else begin
                        expected_bytes = beat.rx_byte[6:0];
                        if (beat.rx_byte == 0) begin
                            drop_frame();
                        end else begin
                            phase = PH_PAYLOAD;
                            received_count = '0;
                            elapsed = '0;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (received_count < BUF_BYTES) payload[received_count] = beat.rx_byte;
                    received_count++;
                    if (received_count >= expected_bytes) begin
                        drop_frame();
                        case (8'(expected_bytes))
                            BYTES_BANK0: queue_run(BANK_SIX, 6, 1'b0);
                            BYTES_BANK1: queue_run(BANK_SIXTEEN, 16, 1'b0);
                            BYTES_BANK2: queue_run(BANK_ONE, 1, 1'b0);
                            BYTES_BANK3: queue_run(BANK_WIDE, 22, beat.write_pending);
                            default: ;
                        endcase
                    end
                end
                default: begin
                    phase = PH_HUNT;
                    if (beat.rx_byte == slave_address) begin
                        phase = PH_HEADER;
                        received_count = '0;
                        elapsed = '0;
                    end
                end
            endcase
        endfunction

        function void check_word(out_beat_t got);
            out_beat_t want;
            if (awaited_words.size() == 0) begin
                $error("word beat with none expected: bank %0d index %0d value %h",
                       got.bank, got.word_index, got.word_value);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            if (got.bank !== want.bank) begin
                $error("bank: expected %0d, actual %0d", want.bank, got.bank);
                errors++;
            end
            if (got.word_index !== want.word_index) begin
                $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
                errors++;
            end
            if (got.word_value !== want.word_value) begin
                $error("word_value: expected %h, actual %h", want.word_value, got.word_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, got.last);
                errors++;
            end
            if (got.write_grant !== want.write_grant) begin
                $error("write_grant: expected %b, actual %b", want.write_grant, got.write_grant);
                errors++;
            end
        endfunction
    endclass

endpackage

@@ verif/modbus_response_sniffer_test.sv @@
`timescale 1ns / 1ps
// top-level test of modbus_response_sniffer: directed and random byte/tick
// beats with bursty input, stalling output and several register settings
// depends on msniff_pkg, msniff_scoreboard_pkg and the sniffer rtl
module modbus_response_sniffer_test;
    import msniff_pkg::*;
    import msniff_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BEATS = 6;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    register_word_tracker tracker;

    int burst_left = 0;
    int beats_sent = 0;
    bit hold_armed = 0;
    int hold_left = 0;
    int style_sel = 0;
    int style_left = 0;
    int pat_cnt = 0;
    int quiet_cycles = 0;

    modbus_response_sniffer #(
        .BUFFER_BYTES(64)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // output monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_word(m_data);
        if (aresetn && hold_armed && tracker.waiting() > 0) begin
            hold_left = HOLD_CYCLES;
            hold_armed = 0;
        end
        pat_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                style_sel = $urandom_range(0, 3);
                style_left = $urandom_range(20, 150);
            end else begin
                style_left--;
            end
            case (style_sel)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (pat_cnt % 3 != 2);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(input logic mode, input logic [7:0] value, input logic pend);
        in_beat_t beat;
        beat.mode = mode;
        beat.rx_byte = value;
        beat.write_pending = pend;
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        tracker.take_beat(beat);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_tick();
        send_beat(MODE_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic drain_words();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (tracker.waiting() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] addr, input logic [15:0] hdr_limit,
                             input logic [15:0] pay_limit);
        drain_words();
        write_reg(REG_SLAVE_ADDRESS, {8'h00, addr});
        write_reg(REG_HEADER_LIMIT, hdr_limit);
        write_reg(REG_PAYLOAD_LIMIT, pay_limit);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] count, input int npay,
                              input int hdr_ticks, input int pay_ticks,
                              input logic pend_last, input bit with_crc);
        int split;
        int ticks_at [64];
        foreach (ticks_at[i]) ticks_at[i] = 0;
        send_beat(MODE_BYTE, addr, 1'($urandom));
        split = $urandom_range(0, hdr_ticks);
        repeat (split) send_tick();
        send_beat(MODE_BYTE, func, 1'($urandom));
        repeat (hdr_ticks - split) send_tick();
        send_beat(MODE_BYTE, count, 1'($urandom));
        if (npay > 0)
            repeat (pay_ticks) ticks_at[$urandom_range(0, npay - 1)]++;
        for (int i = 0; i < npay; i++) begin
            repeat (ticks_at[i]) send_tick();
            send_beat(MODE_BYTE, 8'($urandom), (i == npay - 1) ? pend_last : 1'($urandom));
        end
        if (with_crc) repeat (2) send_beat(MODE_BYTE, 8'($urandom), 1'($urandom));
    endtask

    // ticks to spend in one phase of a frame; overrun asks for one past the limit when the limit is at most 8
    function automatic int pick_ticks(input logic [15:0] limit, input bit overrun);
        if (overrun && limit <= 8) return int'(limit) + 1;
        return $urandom_range(0, (limit < 3) ? int'(limit) : 3);
    endfunction

    task automatic random_frame();
        int r;
        int sel;
        logic [7:0] addr;
        logic [7:0] count;
        logic [7:0] func;
        bit in_header;
        r = $urandom_range(0, 99);
        addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : tracker.slave_address;
        if (r < 10) begin
            repeat ($urandom_range(1, 4))
                send_beat(1'($urandom), 8'($urandom), 1'($urandom));
        end else if (r < 68) begin
            sel = $urandom_range(0, 9);
            if (r >= 60) count = 8'($urandom_range(1, 64));
            else if (sel < 4) count = BYTES_BANK2;
            else if (sel < 7) count = BYTES_BANK0;
            else if (sel < 9) count = BYTES_BANK1;
            else count = BYTES_BANK3;
            send_frame(addr, FUNC_READ_HOLDING, count, int'(count),
                       pick_ticks(tracker.header_limit, 0),
                       pick_ticks(tracker.payload_limit, 0),
                       1'($urandom), $urandom_range(0, 3) != 0);
        end else if (r < 74) begin
            send_frame(addr, FUNC_READ_HOLDING, 8'd0, 0,
                       pick_ticks(tracker.header_limit, 0), 0, 1'($urandom), 1);
        end else if (r < 80) begin
            send_frame(addr, FUNC_READ_HOLDING, 8'($urandom_range(65, 255)), 0,
                       pick_ticks(tracker.header_limit, 0), 0, 1'($urandom), 1);
        end else if (r < 88) begin
            func = 8'($urandom);
            if (func == FUNC_READ_HOLDING) func = 8'h83;
            count = 8'($urandom_range(1, 12));
            send_frame(addr, func, count, int'(count), pick_ticks(tracker.header_limit, 0), 0,
                       1'($urandom), 1);
        end else if (r < 96) begin
            count = ($urandom_range(0, 1) == 0) ? BYTES_BANK2 : BYTES_BANK0;
            in_header = 1'($urandom_range(0, 1));
            send_frame(addr, FUNC_READ_HOLDING, count, int'(count),
                       pick_ticks(tracker.header_limit, in_header),
                       pick_ticks(tracker.payload_limit, !in_header),
                       1'($urandom), 1);
        end else begin
            send_frame(addr, FUNC_READ_HOLDING, BYTES_BANK0, $urandom_range(1, 11),
                       0, 0, 1'($urandom), 0);
        end
    endtask

    initial begin
        int stop_at;
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings
        send_beat(MODE_TICK, 8'hFF, 1'b1);
        send_beat(MODE_BYTE, 8'h00, 1'b0);
        send_beat(MODE_BYTE, 8'hFF, 1'b1);
        send_beat(MODE_BYTE, RESET_SLAVE_ADDRESS, 1'b0);
        send_beat(MODE_BYTE, FUNC_READ_HOLDING, 1'b1);
        send_beat(MODE_BYTE, BYTES_BANK2, 1'b0);
        send_beat(MODE_BYTE, 8'hFF, 1'b0);
        send_beat(MODE_BYTE, 8'h00, 1'b1);
        send_frame(RESET_SLAVE_ADDRESS, FUNC_READ_HOLDING, 8'd0, 0, 0, 0, 1'b0, 0);
        send_frame(RESET_SLAVE_ADDRESS, FUNC_READ_HOLDING, 8'd65, 0, 0, 0, 1'b0, 0);
        send_frame(RESET_SLAVE_ADDRESS, 8'h04, BYTES_BANK2, 0, 0, 0, 1'b0, 0);
        send_frame(RESET_SLAVE_ADDRESS, FUNC_READ_HOLDING, 8'd5, 5, 0, 0, 1'b1, 0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: configure(8'h00, 16'd0, 16'hFFFF);
                1: configure(8'hFF, 16'hFFFF, 16'd0);
                2: configure(8'($urandom), 16'($urandom_range(1, 6)),
                             16'($urandom_range(1, 6)));
                3: configure(8'($urandom), 16'($urandom_range(0, 3)),
                             16'($urandom_range(3, 8)));
                default: begin
                    configure(8'($urandom), RESET_HEADER_LIMIT, RESET_PAYLOAD_LIMIT);
                    hold_armed = 1;
                    send_frame(tracker.slave_address, FUNC_READ_HOLDING, BYTES_BANK3, 44,
                               0, 0, 1'b1, 1);
                    send_frame(tracker.slave_address, FUNC_READ_HOLDING, BYTES_BANK3, 44,
                               1, 2, 1'b0, 1);
                end
            endcase
            stop_at = beats_sent + PHASE_BEATS;
            while (beats_sent < stop_at) random_frame();
        end

        drain_words();
        if (tracker.errors == 0 && tracker.waiting() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
